// File: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, off during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clk, off during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sha256_pkg.sv
// Types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_DONE
  } state_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  localparam logic [31:0] INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: hdl/sha256_stream_hasher.sv
// SHA-256 stream hasher: byte collection, padding, shared round unit, digest output.
//
//   channel | direction | payload                                       | handshake
//   in_     | input     | in_data_byte, in_has_byte, in_last            | in_valid / in_stall
//   out_    | output    | out_digest_word, out_word_index, out_last_word | out_valid / out_stall
//
// Bytes are taken one per cycle while in_stall is low; the 64th byte of a block starts the
// rounds of the one shared round unit, then the chaining add, with in_stall high throughout.
// On last the sequencer pushes padding one byte per cycle, pausing for the rounds when a
// block fills (9 to 72 bytes, one or two blocks), then copies the digest to the output
// register and resets the chaining state. The digest drains one word per transfer while the
// next message is taken; a second digest waits for the output register to empty. Reset
// (rst_n low, synchronous) reloads the initial chaining value and clears counters and out_valid.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256_pkg::state_t state_r, state_nxt;

  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [23:0] word_r;
  logic [31:0] w_r [0:15];
  logic [31:0] v_r [0:7];
  logic [31:0] h_r [0:7];
  logic [31:0] dig_r [0:7];
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic        sent80_r;
  logic        ovf_r;
  logic        lastblk_r;
  logic [2:0]  out_idx_r;
  logic        out_busy_r;

  logic        in_xfer;
  logic        push;
  logic        wrap;
  logic        out_xfer;
  logic        done_go;
  logic [7:0]  pad_byte;
  logic [7:0]  push_byte;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] w_new;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (wrap) begin
            state_nxt = sha256_pkg::ST_ROUND;
          end else if (in_last) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd_r == sha256_pkg::LAST_ROUND) begin
          state_nxt = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_UPDATE: begin
        if (lastblk_r) begin
          state_nxt = sha256_pkg::ST_DONE;
        end else if (fin_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (wrap) begin
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_DONE: begin
        if (!out_busy_r) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != sha256_pkg::ST_IDLE);
    in_xfer  = in_valid && !in_stall;
    push     = (in_xfer && in_has_byte) || (state_r == sha256_pkg::ST_PAD);
    wrap     = push && (fill_r == sha256_pkg::LAST_BYTE);
    done_go  = (state_r == sha256_pkg::ST_DONE) && !out_busy_r;
    out_xfer = out_busy_r && !out_stall;
  end

  always_comb begin
    if (!sent80_r) begin
      pad_byte = sha256_pkg::PAD_BYTE;
    end else if (ovf_r || (fill_r < sha256_pkg::LEN_OFFSET)) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bits_r[8 * (3'd7 - fill_r[2:0]) +: 8];
    end
    push_byte = (state_r == sha256_pkg::ST_PAD) ? pad_byte : in_data_byte;
  end

  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sha256_pkg::big_sig1(v_r[4]) + ch + sha256_pkg::ROUND_K[rnd_r] + w_r[0];
    t2    = sha256_pkg::big_sig0(v_r[0]) + maj;
    w_new = sha256_pkg::small_sig1(w_r[14]) + w_r[9] + sha256_pkg::small_sig0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256_pkg::ST_IDLE;
      fill_r     <= '0;
      bits_r     <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      sent80_r   <= 1'b0;
      ovf_r      <= 1'b0;
      lastblk_r  <= 1'b0;
      out_idx_r  <= '0;
      out_busy_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha256_pkg::INIT_HASH[i];
      end
    end else begin
      state_r <= state_nxt;

      if (in_xfer && in_has_byte) begin
        bits_r <= bits_r + 64'd8;
      end
      if (in_xfer && in_last) begin
        fin_r <= 1'b1;
      end

      if (push) begin
        fill_r <= fill_r + 6'd1;
      end
      if (state_r == sha256_pkg::ST_PAD) begin
        sent80_r <= 1'b1;
        if (!sent80_r && (fill_r >= sha256_pkg::LEN_OFFSET) && !wrap) begin
          ovf_r <= 1'b1;
        end
        if (wrap) begin
          ovf_r     <= 1'b0;
          lastblk_r <= sent80_r && !ovf_r;
        end
      end

      if (wrap) begin
        rnd_r <= '0;
      end else if (state_r == sha256_pkg::ST_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end

      if (state_r == sha256_pkg::ST_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end

      if (done_go) begin
        fin_r      <= 1'b0;
        sent80_r   <= 1'b0;
        lastblk_r  <= 1'b0;
        bits_r     <= '0;
        out_busy_r <= 1'b1;
        out_idx_r  <= '0;
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= sha256_pkg::INIT_HASH[i];
        end
      end else if (out_xfer) begin
        out_idx_r <= out_idx_r + 3'd1;
        if (out_idx_r == sha256_pkg::LAST_WORD) begin
          out_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_r <= {word_r[15:0], push_byte};
    end
    if (push && (fill_r[1:0] == 2'd3)) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= {word_r, push_byte};
    end else if (state_r == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_new;
    end

    if (wrap) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (state_r == sha256_pkg::ST_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end

    if (done_go) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= h_r[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < 7; i++) begin
        dig_r[i] <= dig_r[i + 1];
      end
    end
  end

  assign out_valid       = out_busy_r;
  assign out_digest_word = dig_r[0];
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == sha256_pkg::LAST_WORD);

endmodule

// File: hdl/sha256_checker.sv
// Port-level checks of the SHA-256 stream hasher and their bind.
`include "assert_macros.svh"

module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_digest_word) && $stable(out_word_index), "stalled digest word changed")

  `CHK_NEXT(a_word_order, out_valid && !out_stall && (out_word_index != 3'd7), out_valid && (out_word_index == $past(out_word_index) + 3'd1), "digest words out of order")

  `CHK_NEXT(a_last_busy, in_valid && !in_stall && in_last, in_stall, "input taken during padding")

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index)
);
